@@ hdl/u16550_pkg.sv @@
// Package with shared types, constants and opcode names for the UART register block.
package u16550_pkg;

   localparam int FifoDepth = 16;
   localparam int PtrW = $clog2(FifoDepth);
   localparam int FillW = $clog2(FifoDepth + 1);
   localparam int QDepth = 2;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RXCH  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   localparam logic [2:0] REG_RBR = 3'd0;
   localparam logic [2:0] REG_IER = 3'd1;
   localparam logic [2:0] REG_IIR = 3'd2;
   localparam logic [2:0] REG_LCR = 3'd3;
   localparam logic [2:0] REG_MCR = 3'd4;
   localparam logic [2:0] REG_LSR = 3'd5;
   localparam logic [2:0] REG_SCR = 3'd7;

   localparam logic [7:0] IIR_NONE = 8'h01;
   localparam logic [7:0] IIR_THRE = 8'h02;
   localparam logic [7:0] IIR_RDA  = 8'h04;
   localparam logic [7:0] IIR_LINE = 8'h06;

   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] line_byte;
      logic       line_framing_error;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq;
   } rsp_type;

   // Receive trigger level for a trigger code, saturated at the FIFO depth.
   function automatic logic [FillW-1:0] trig_level(input logic [1:0] code);
      int t;
      begin
         case (code)
            2'd0: t = 1;
            2'd1: t = 4;
            2'd2: t = 8;
            default: t = 14;
         endcase
         if (t > FifoDepth) t = FifoDepth;
         trig_level = FillW'(t);
      end
   endfunction

endpackage

@@ hdl/uart_16550_register_block_unit.sv @@
// Top level of the 16550-style UART register block.
// Each accepted word (register read, register write, received character or baud tick)
// produces exactly one result word. A word enters a front register, waits in a two-entry
// queue, and is executed by the register engine, so one word per clock is sustained
// unless the result side stalls; between acceptance and result lie the front register,
// the queue and the engine's output register. A character is sent after 160 times the
// divisor in baud ticks; irq reflects the state after each word, gated by MCR OUT2.
module uart_16550_register_block_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  u16550_pkg::req_type  req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output u16550_pkg::rsp_type  rsp_word
);
   logic                f_valid, f_stall, q_valid, q_stall;
   u16550_pkg::req_type f_word, q_word;

   u16550_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .out_valid(f_valid), .out_stall(f_stall), .out_word(f_word)
   );

   u16550_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_word(f_word),
      .out_valid(q_valid), .out_stall(q_stall), .out_word(q_word)
   );

   u16550_engine u_engine (
      .clock, .reset, .in_valid(q_valid), .in_stall(q_stall), .in_word(q_word),
      .rsp_valid, .rsp_stall, .rsp_word
   );
endmodule

@@ hdl/u16550_queue.sv @@
// Two-entry word queue between the front end and the register engine.
module u16550_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  u16550_pkg::req_type  in_word,
   output logic                 out_valid,
   input  logic                 out_stall,
   output u16550_pkg::req_type  out_word
);
   u16550_pkg::req_type mem_ff [u16550_pkg::QDepth];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_word;
   end
endmodule

@@ hdl/u16550_front.sv @@
// Front end: registers incoming words and zeroes unused data and line fields.
module u16550_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  u16550_pkg::req_type  req_word,
   output logic                 out_valid,
   input  logic                 out_stall,
   output u16550_pkg::req_type  out_word
);
   logic                valid_ff, valid_in;
   u16550_pkg::req_type word_ff, word_in;

   assign req_stall = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Classify: zero the write data and line fields an operation does not use.
   always_comb begin
      word_in = req_word;
      if (req_word.operation != u16550_pkg::OP_RXCH) begin
         word_in.line_byte = 8'd0;
         word_in.line_framing_error = 1'b0;
      end
      if (req_word.operation != u16550_pkg::OP_WRITE) word_in.write_data = 8'd0;
      valid_in = req_stall ? valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (!req_stall) word_ff <= word_in;
   end
endmodule

@@ hdl/u16550_engine.sv @@
// Register engine: one word per cycle when not stalled; result held in an output register.
module u16550_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  u16550_pkg::req_type  in_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output u16550_pkg::rsp_type  rsp_word
);
   localparam int PW = u16550_pkg::PtrW;
   localparam int FW = u16550_pkg::FillW;
   localparam int Depth = u16550_pkg::FifoDepth;

   logic [15:0] dl_ff, dl_in;
   logic [3:0]  ier_ff, ier_in;
   logic [7:0]  lcr_ff, lcr_in;
   logic [4:0]  mcr_ff, mcr_in;
   logic [7:0]  scr_ff, scr_in;
   logic [2:0]  fcr_ff, fcr_in;
   logic [PW-1:0] rx_rp_ff, rx_rp_in, tx_rp_ff, tx_rp_in;
   logic [FW-1:0] rx_fill_ff, rx_fill_in, tx_fill_ff, tx_fill_in;
   logic        busy_ff, busy_in;
   logic [7:0]  sh_ff, sh_in;
   logic [23:0] tick_ff, tick_in;
   logic [23:0] limit_ff;
   logic        oe_ff, oe_in, fe_ff, fe_in, thre_ff, thre_in;
   logic [8:0]  rx_mem [Depth];
   logic [7:0]  tx_mem [Depth];
   logic        rv_ff, rv_in;
   u16550_pkg::rsp_type rsp_ff, rsp_in;

   logic          go, dlab, fen;
   logic [FW-1:0] cap;
   logic          rx_we, tx_we;
   logic [PW-1:0] rx_wa, tx_wa, rx_next;
   logic [8:0]    rx_wd;
   logic [7:0]    rd, iir;
   logic [7:0]    iir_out;

   assign in_stall  = rv_ff && rsp_stall;
   assign go        = in_valid && !in_stall;
   assign rsp_valid = rv_ff;
   assign rsp_word  = rsp_ff;
   assign dlab      = lcr_ff[7];
   assign fen       = fcr_ff[0];
   assign cap       = fen ? FW'(Depth) : FW'(1);
   assign rx_next   = rx_rp_ff + PW'(1);

   // Interrupt identification for a given state.
   function automatic logic [7:0] iir_of(input logic [3:0] ie, input logic oe,
         input logic fe, input logic [FW-1:0] fill, input logic [2:0] fc,
         input logic th);
      logic [FW-1:0] trg;
      begin
         trg = fc[0] ? u16550_pkg::trig_level(fc[2:1]) : FW'(1);
         if (ie[2] && (oe || fe)) iir_of = u16550_pkg::IIR_LINE;
         else if (ie[0] && fill >= trg) iir_of = u16550_pkg::IIR_RDA;
         else if (ie[1] && th) iir_of = u16550_pkg::IIR_THRE;
         else iir_of = u16550_pkg::IIR_NONE;
      end
   endfunction

   assign iir = iir_of(ier_ff, oe_ff, fe_ff, rx_fill_ff, fcr_ff, thre_ff);

   // Execute one word.
   always_comb begin
      dl_in = dl_ff; ier_in = ier_ff; lcr_in = lcr_ff; mcr_in = mcr_ff;
      scr_in = scr_ff; fcr_in = fcr_ff;
      rx_rp_in = rx_rp_ff; rx_fill_in = rx_fill_ff;
      tx_rp_in = tx_rp_ff; tx_fill_in = tx_fill_ff;
      busy_in = busy_ff; sh_in = sh_ff; tick_in = tick_ff;
      oe_in = oe_ff; fe_in = fe_ff; thre_in = thre_ff;
      rx_we = 1'b0; tx_we = 1'b0;
      rx_wa = rx_rp_ff + PW'(rx_fill_ff);
      tx_wa = tx_rp_ff + PW'(tx_fill_ff);
      rx_wd = {in_word.line_framing_error, in_word.line_byte};
      rd = 8'd0;
      rsp_in = '0;
      iir_out = 8'd0;
      if (go) begin
         unique case (u16550_pkg::op_type'(in_word.operation))
            u16550_pkg::OP_READ: begin
               case (in_word.reg_offset)
                  u16550_pkg::REG_RBR: begin
                     if (dlab) rd = dl_ff[7:0];
                     else if (rx_fill_ff != '0) begin
                        rd = rx_mem[rx_rp_ff][7:0];
                        rx_rp_in = rx_next;
                        rx_fill_in = rx_fill_ff - FW'(1);
                        if (rx_fill_in != '0 && rx_mem[rx_next][8]) fe_in = 1'b1;
                     end
                  end
                  u16550_pkg::REG_IER: rd = dlab ? dl_ff[15:8] : {4'd0, ier_ff};
                  u16550_pkg::REG_IIR: begin
                     if (iir == u16550_pkg::IIR_THRE) thre_in = 1'b0;
                     rd = iir | (fen ? 8'hC0 : 8'h00);
                  end
                  u16550_pkg::REG_LCR: rd = lcr_ff;
                  u16550_pkg::REG_MCR: rd = {3'd0, mcr_ff};
                  u16550_pkg::REG_LSR: begin
                     rd = {1'b0, (tx_fill_ff == '0) && !busy_ff, tx_fill_ff == '0,
                           1'b0, fe_ff, 1'b0, oe_ff, rx_fill_ff != '0};
                     oe_in = 1'b0; fe_in = 1'b0;
                  end
                  u16550_pkg::REG_SCR: rd = scr_ff;
                  default: rd = 8'd0;
               endcase
            end
            u16550_pkg::OP_WRITE: begin
               case (in_word.reg_offset)
                  u16550_pkg::REG_RBR: begin
                     if (dlab) dl_in[7:0] = in_word.write_data;
                     else begin
                        if (tx_fill_ff < cap) begin
                           tx_we = 1'b1;
                           tx_fill_in = tx_fill_ff + FW'(1);
                        end
                        thre_in = 1'b0;
                     end
                  end
                  u16550_pkg::REG_IER: begin
                     if (dlab) dl_in[15:8] = in_word.write_data;
                     else begin
                        if (in_word.write_data[1] && !ier_ff[1] && tx_fill_ff == '0)
                           thre_in = 1'b1;
                        ier_in = in_word.write_data[3:0];
                     end
                  end
                  u16550_pkg::REG_IIR: begin
                     if (in_word.write_data[0] != fen || in_word.write_data[1]) begin
                        rx_rp_in = '0; rx_fill_in = '0;
                     end
                     if (in_word.write_data[0] != fen || in_word.write_data[2]) begin
                        if (tx_fill_ff != '0) thre_in = 1'b1;
                        tx_rp_in = '0; tx_fill_in = '0;
                     end
                     fcr_in = {in_word.write_data[7:6], in_word.write_data[0]};
                  end
                  u16550_pkg::REG_LCR: lcr_in = in_word.write_data;
                  u16550_pkg::REG_MCR: mcr_in = in_word.write_data[4:0];
                  u16550_pkg::REG_SCR: scr_in = in_word.write_data;
                  default: ;
               endcase
            end
            u16550_pkg::OP_RXCH: begin
               if (rx_fill_ff < cap) begin
                  rx_we = 1'b1;
                  if (rx_fill_ff == '0 && in_word.line_framing_error) fe_in = 1'b1;
                  rx_fill_in = rx_fill_ff + FW'(1);
               end else begin
                  oe_in = 1'b1;
                  if (!fen) begin
                     rx_we = 1'b1;
                     rx_wa = rx_rp_ff;
                     if (in_word.line_framing_error) fe_in = 1'b1;
                  end
               end
            end
            u16550_pkg::OP_TICK: begin
               if (dl_ff != 16'd0) begin
                  if (busy_ff) begin
                     tick_in = tick_ff + 24'd1;
                     if (tick_in >= limit_ff) begin
                        rsp_in.tx_valid = 1'b1;
                        rsp_in.tx_byte = sh_ff;
                        busy_in = 1'b0;
                        tick_in = 24'd0;
                     end
                  end
                  if (!busy_in && tx_fill_ff != '0) begin
                     sh_in = tx_mem[tx_rp_ff];
                     tx_rp_in = tx_rp_ff + PW'(1);
                     tx_fill_in = tx_fill_ff - FW'(1);
                     busy_in = 1'b1;
                     tick_in = 24'd0;
                     if (tx_fill_in == '0) thre_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         iir_out = iir_of(ier_in, oe_in, fe_in, rx_fill_in, fcr_in, thre_in);
         rsp_in.read_data = rd;
         rsp_in.irq = (iir_out != u16550_pkg::IIR_NONE) && mcr_in[3];
      end
      rv_in = go ? 1'b1 : (rv_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff <= '0; ier_ff <= '0; lcr_ff <= '0; mcr_ff <= '0; scr_ff <= '0;
         fcr_ff <= '0; rx_rp_ff <= '0; rx_fill_ff <= '0; tx_rp_ff <= '0;
         tx_fill_ff <= '0; busy_ff <= 1'b0; sh_ff <= '0; tick_ff <= '0;
         oe_ff <= 1'b0; fe_ff <= 1'b0; thre_ff <= 1'b0; rv_ff <= 1'b0;
         limit_ff <= '0;
      end else begin
         dl_ff <= dl_in; ier_ff <= ier_in; lcr_ff <= lcr_in; mcr_ff <= mcr_in;
         scr_ff <= scr_in; fcr_ff <= fcr_in; rx_rp_ff <= rx_rp_in;
         rx_fill_ff <= rx_fill_in; tx_rp_ff <= tx_rp_in; tx_fill_ff <= tx_fill_in;
         busy_ff <= busy_in; sh_ff <= sh_in; tick_ff <= tick_in;
         oe_ff <= oe_in; fe_ff <= fe_in; thre_ff <= thre_in; rv_ff <= rv_in;
         // Character time: 160 times the divisor, as (dl << 7) + (dl << 5).
         limit_ff <= 24'({dl_in, 7'd0}) + 24'({dl_in, 5'd0});
      end
   end

   // Result register, held while stalled.
   always_ff @(posedge clock) begin
      if (go) rsp_ff <= rsp_in;
   end

   // FIFO storage.
   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_wa] <= rx_wd;
      if (tx_we) tx_mem[tx_wa] <= in_word.write_data;
   end
endmodule

@@ hdl/u16550_checker.sv @@
// Port-level checker for the UART register block, bound to the top level.
module u16550_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input u16550_pkg::req_type req_word,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input u16550_pkg::rsp_type rsp_word
);
   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // A finished character never comes with read data.
   a_tx_rd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.tx_valid |-> rsp_word.read_data == 8'd0)
      else $error("read data on a transmit result");

   // An idle result side never holds off requests.
   a_nostall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result side");

   // No result in the cycle after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");
endmodule

bind uart_16550_register_block_unit u16550_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall, .rsp_word
);
